// ===== sv/swer_pkg.sv =====
package swer_pkg;

    // Field widths
    localparam int CNT_W     = 11;
    localparam int PCT_W     = 15;
    localparam int PROD_W    = 26;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 40;

    // Percent scale: 100 with 8 fraction bits
    localparam int SCALE     = 25600;

    // Quotient never exceeds SCALE, so 15 quotient bits suffice
    localparam int DIV_STEPS = PCT_W;
    localparam int STEP_W    = 4;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_start;  // reset counters, restart ring clear
        logic clear_step;   // zero one ring entry
        logic capture;      // latch event and slot on input beat
        logic update;       // write ring, update tally, index and fill
        logic mul;          // load tally * scale into divider
        logic div_step;     // one restoring divide step
        logic load_out;     // move result into output register
    } swer_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;   // last ring entry being cleared
        logic div_last;     // last divide step
    } swer_status_t;

endpackage

// ===== sv/swer_ctrl.sv =====
module swer_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  cfg_fire,
    input  swer_pkg::swer_status_t status,
    output swer_pkg::swer_cmd_t   cmd
);
    import swer_pkg::*;

    typedef enum logic [6:0] {
        CLEAR_S  = 7'b0000001,
        IDLE_S   = 7'b0000010,
        READ_S   = 7'b0000100,
        UPDATE_S = 7'b0001000,
        MUL_S    = 7'b0010000,
        DIV_S    = 7'b0100000,
        DONE_S   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == IDLE_S);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            CLEAR_S:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = IDLE_S;
                end
            end
            IDLE_S:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = READ_S;
                end
            end
            READ_S:
            begin
                state_next = UPDATE_S;
            end
            UPDATE_S:
            begin
                cmd.update = 1'b1;
                state_next = MUL_S;
            end
            MUL_S:
            begin
                cmd.mul    = 1'b1;
                state_next = DIV_S;
            end
            DIV_S:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = DONE_S;
                end
            end
            DONE_S:
            begin
                // output register free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE_S;
                end
            end
            default:
            begin
                state_next = CLEAR_S;
            end
        endcase
        // length write restarts the clear
        if (cfg_fire)
        begin
            cmd             = '0;
            cmd.clear_start = 1'b1;
            state_next      = CLEAR_S;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR_S;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/swer_dpath.sv =====
module swer_dpath #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swer_pkg::swer_cmd_t           cmd,
    output swer_pkg::swer_status_t        status,
    input  logic [swer_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          event_value,
    output logic [swer_pkg::CNT_W-1:0]    true_count,
    output logic [swer_pkg::CNT_W-1:0]    seen_total,
    output logic [swer_pkg::PCT_W-1:0]    true_percent_q8
);
    import swer_pkg::*;

    localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LIM     = (WINDOW_MAX > 2047) ? 2047 : WINDOW_MAX;
    localparam int RST_LEN = (WINDOW_MAX < 1024) ? WINDOW_MAX : 1024;
    localparam logic [CNT_W-1:0] LEN_MAX  = CNT_W'(LIM);
    localparam logic [CNT_W-1:0] LEN_RST  = CNT_W'(RST_LEN);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(WINDOW_MAX - 1);

    // Event ring
    logic             ring [WINDOW_MAX];
    logic             rd_bit_reg;

    // Control state
    logic [CNT_W-1:0] len_reg,      len_next;
    logic [CNT_W-1:0] ring_idx_reg, ring_idx_next;
    logic [CNT_W-1:0] tally_reg,    tally_next;
    logic [CNT_W-1:0] fill_reg,     fill_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0] step_reg,    step_next;

    // Payload
    logic              ev_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PCT_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [CNT_W-1:0]  tot_out_reg;
    logic [PCT_W-1:0]  pct_out_reg;

    logic [CNT_W-1:0]  cfg_len;
    logic [CNT_W-1:0]  slot_c;
    logic [IDX_W-1:0]  slot_addr;
    logic [PROD_W-1:0] dsh;
    logic              ge;

    // Written length clamped to 1..LEN_MAX
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_len = CNT_W'(1);
        end
        else if (cfg_data > LEN_MAX)
        begin
            cfg_len = LEN_MAX;
        end
        else
        begin
            cfg_len = cfg_data;
        end
    end

    // Slot falls back to 0 if index beyond length
    assign slot_c    = (ring_idx_reg >= len_reg) ? '0 : ring_idx_reg;
    assign slot_addr = IDX_W'(slot_reg);

    // Divider trial subtract
    assign dsh = PROD_W'(fill_reg) << step_reg;
    assign ge  = (rem_reg >= dsh);

    assign status.clear_last = (clr_addr_reg == CLR_LAST);
    assign status.div_last   = (step_reg == '0);

    // Counter and index updates
    always_comb
    begin
        len_next      = len_reg;
        ring_idx_next = ring_idx_reg;
        tally_next    = tally_reg;
        fill_next     = fill_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        if (cmd.clear_start)
        begin
            len_next      = cfg_len;
            ring_idx_next = '0;
            tally_next    = '0;
            fill_next     = '0;
            clr_addr_next = '0;
        end
        if (cmd.clear_step && !status.clear_last)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
        end
        if (cmd.update)
        begin
            if (rd_bit_reg != ev_reg)
            begin
                if (ev_reg)
                begin
                    tally_next = tally_reg + CNT_W'(1);
                end
                else if (tally_reg != '0)
                begin
                    tally_next = tally_reg - CNT_W'(1);
                end
            end
            if (slot_reg == '0)
            begin
                ring_idx_next = len_reg - CNT_W'(1);
            end
            else
            begin
                ring_idx_next = slot_reg - CNT_W'(1);
            end
            if (fill_reg < len_reg)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (cmd.mul)
        begin
            step_next = STEP_W'(DIV_STEPS - 1);
        end
        if (cmd.div_step && !status.div_last)
        begin
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_RST;
            ring_idx_reg <= '0;
            tally_reg    <= '0;
            fill_reg     <= '0;
            clr_addr_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            len_reg      <= len_next;
            ring_idx_reg <= ring_idx_next;
            tally_reg    <= tally_next;
            fill_reg     <= fill_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
        end
    end

    // Ring memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            ring[clr_addr_reg] <= 1'b0;
        end
        else if (cmd.update)
        begin
            ring[slot_addr] <= ev_reg;
        end
        rd_bit_reg <= ring[slot_addr];
    end

    // Item payload, multiply and restoring divide
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_reg   <= event_value;
            slot_reg <= slot_c;
        end
        if (cmd.mul)
        begin
            rem_reg <= PROD_W'(tally_reg) * PROD_W'(SCALE);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh;
            end
            quo_reg <= {quo_reg[PCT_W-2:0], ge};
        end
        if (cmd.load_out)
        begin
            cnt_out_reg <= tally_reg;
            tot_out_reg <= fill_reg;
            pct_out_reg <= quo_reg;
        end
    end

    assign true_count      = cnt_out_reg;
    assign seen_total      = tot_out_reg;
    assign true_percent_q8 = pct_out_reg;

endmodule

// ===== sv/sliding_window_event_ratio_core.sv =====
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       s_tdata[0] event_value
// m_*       out  m_tvalid / m_tready       m_tdata true_count, seen_total, true_percent_q8
// cfg_*     in   cfg_valid / cfg_ready     cfg_data window_length
//
// Each event passes from input beat to result through ring read, update,
// multiply, then a 15-step restoring divide by the fill level.
// After reset and after each length write the ring is cleared one bit per
// cycle over all WINDOW_MAX entries; no input beat is taken meanwhile.
// A result waits in the output register; the next event is taken meanwhile
// and stalls only in its last cycle if that register is still full.
module sliding_window_event_ratio_core #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] event_value, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [10:0] true_count, [21:11] seen_total,
                                    // [36:22] true_percent_q8, [39:37] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data    // window_length
);
    import swer_pkg::*;

    swer_cmd_t        cmd;
    swer_status_t     status;
    logic             cfg_fire;
    logic [CNT_W-1:0] true_count;
    logic [CNT_W-1:0] seen_total;
    logic [PCT_W-1:0] true_percent_q8;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    swer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cfg_fire  (cfg_fire),
        .status    (status),
        .cmd       (cmd)
    );

    swer_dpath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_data        (cfg_data),
        .event_value     (s_tdata[0]),
        .true_count      (true_count),
        .seen_total      (seen_total),
        .true_percent_q8 (true_percent_q8)
    );

    assign m_tdata = {3'b000, true_percent_q8, seen_total, true_count};

    // One event in flight: no beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while event in flight");

    // Length write starts a clear pass
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !s_tready)
        else $error("input ready during ring clear");

    // Result consistency: tally within fill, percent within scale
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (true_count <= seen_total) && (seen_total != '0) &&
                     (true_percent_q8 <= PCT_W'(SCALE)))
        else $error("result out of range");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swer_pkg::*;

    localparam int WINDOW_MAX  = 1024;
    localparam int WATCHDOG    = 5000;  // cycles with no beat anywhere
    localparam int TAIL_CYCLES = 30;    // settle time after the last result

    // Receiver behavior
    typedef enum logic [0:0] {
        RX_FREE,
        RX_PATTERN
    } rx_mode_t;

    // One expected result beat
    typedef struct {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] seen;
        logic [PCT_W-1:0] pct;
    } ratio_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data = '0;

    // Window shadow state
    bit [WINDOW_MAX-1:0] event_ring;
    int unsigned         ring_pos;
    int unsigned         tally;
    int unsigned         fill;
    int unsigned         win_len;

    ratio_t pending_results[$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;

    // Sender burst control
    int tx_gap_max = 0;
    int tx_burst_left = 0;

    // Receiver control
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_hold_cycles = 0;
    logic [15:0] rx_pat = 16'hFFFF;
    int          rx_pat_age = 0;

    sliding_window_event_ratio_core #(
        .WINDOW_MAX (WINDOW_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp the length and clear the window, as a length write does
    function automatic void window_configure(input logic [CNT_W-1:0] raw);
        if (raw == 0)
            win_len = 1;
        else if (raw > WINDOW_MAX)
            win_len = WINDOW_MAX;
        else
            win_len = 32'(raw);
        event_ring = '0;
        ring_pos   = 0;
        tally      = 0;
        fill       = 0;
    endfunction

    // Apply one event to the shadow window and return count, total and percent
    function automatic ratio_t window_advance(input bit ev);
        int unsigned slot;
        ratio_t      r;
        slot = ring_pos;
        if (slot >= win_len)
            slot = 0;
        if (event_ring[slot] != ev)
        begin
            if (ev)
                tally++;
            else if (tally > 0)
                tally--;
            event_ring[slot] = ev;
        end
        ring_pos = (slot == 0) ? win_len - 1 : slot - 1;
        if (fill < win_len)
            fill++;
        r.count = tally[CNT_W-1:0];
        r.seen  = fill[CNT_W-1:0];
        r.pct   = (fill != 0) ? PCT_W'((tally * SCALE) / fill) : '0;
        return r;
    endfunction

    // Offer one event beat; bursts of random length with random gaps between
    task automatic send_event(input bit ev);
        int gap;
        if (tx_burst_left == 0)
        begin
            gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(window_advance(ev));
        tx_burst_left--;
    endtask

    // Stop sending, wait for every result, then let the pipeline settle
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Length register write; only called while the block is idle
    task automatic write_length(input logic [CNT_W-1:0] raw);
        cfg_valid <= 1'b1;
        cfg_data  <= raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        window_configure(raw);
    endtask

    // Default length after reset
    task automatic test_default_length();
        tx_gap_max = 0;
        rx_mode    = RX_FREE;
        send_event(1'b1);
        send_event(1'b1);
        send_event(1'b0);
        send_event(1'b1);
        wait_for_drain();
    endtask

    // Zero length raised to one, length one, short ring with wrap and decrements
    task automatic test_short_windows();
        write_length(11'd0);
        send_event(1'b1);
        send_event(1'b1);
        send_event(1'b0);
        send_event(1'b0);
        send_event(1'b1);
        wait_for_drain();
        write_length(11'd1);
        send_event(1'b0);
        send_event(1'b1);
        wait_for_drain();
        write_length(11'd3);
        send_event(1'b1);
        send_event(1'b1);
        send_event(1'b1);
        send_event(1'b0);
        send_event(1'b1);
        send_event(1'b0);
        send_event(1'b0);
        wait_for_drain();
    endtask

    // Lengths above the maximum clamp to it
    task automatic test_length_clamp();
        write_length(11'h7FF);
        send_event(1'b1);
        send_event(1'b0);
        wait_for_drain();
        write_length(11'd1025);
        send_event(1'b1);
        wait_for_drain();
    endtask

    // Random lengths, mostly short, with idling on both sides
    task automatic test_random_lengths();
        logic [CNT_W-1:0] raw;
        int               n;
        int               bias;
        tx_gap_max = 12;
        rx_mode    = RX_PATTERN;
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 4))
                0: raw = CNT_W'($urandom_range(1, 4));
                1: raw = CNT_W'($urandom_range(5, 40));
                2: raw = CNT_W'($urandom_range(0, 2047));
                3: raw = CNT_W'($urandom_range(1020, 1024));
                default: raw = CNT_W'($urandom_range(41, 200));
            endcase
            write_length(raw);
            n    = $urandom_range(20, 60);
            bias = $urandom_range(0, 100);
            if (phase == 4)
                tx_gap_max = 0;
            else
                tx_gap_max = 12;
            for (int i = 0; i < n; i++)
                send_event($urandom_range(0, 99) < bias);
            wait_for_drain();
        end
    endtask

    // Long receiver hold while the sender keeps offering back to back
    task automatic test_output_backpressure();
        write_length(11'd5);
        tx_gap_max     = 0;
        rx_mode        = RX_FREE;
        rx_hold_cycles = 400;
        for (int i = 0; i < 80; i++)
            send_event(1'($urandom_range(0, 1)));
        wait_for_drain();
    endtask

    // Full-size window, run long enough to saturate and overwrite the ring
    task automatic test_full_window();
        int seg_left;
        int bias;
        write_length(11'd1024);
        rx_mode    = RX_PATTERN;
        tx_gap_max = 8;
        seg_left   = 0;
        bias       = 50;
        for (int i = 0; i < 1100; i++)
        begin
            // biased segments push the tally toward both ends
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(50, 300);
                bias     = 25 * $urandom_range(0, 4);
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            seg_left--;
            send_event($urandom_range(0, 99) < bias);
        end
        wait_for_drain();
    endtask

    // Receiver ready: free, rotating pattern, or a counted hold
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles = rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (rx_mode == RX_FREE)
            m_tready <= 1'b1;
        else
        begin
            if (rx_pat_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: rx_pat = 16'hFFFF;
                    1: rx_pat = 16'($urandom & $urandom);
                    default: rx_pat = 16'($urandom);
                endcase
            end
            rx_pat_age = (rx_pat_age + 1) % 48;
            rx_pat     = {rx_pat[0], rx_pat[15:1]};
            m_tready <= rx_pat[0];
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        ratio_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, got %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[10:0] !== want.count)
                begin
                    $display("%0t: true_count expected %0d got %0d",
                             $time, want.count, m_tdata[10:0]);
                    mismatch_count++;
                end
                if (m_tdata[21:11] !== want.seen)
                begin
                    $display("%0t: seen_total expected %0d got %0d",
                             $time, want.seen, m_tdata[21:11]);
                    mismatch_count++;
                end
                if (m_tdata[36:22] !== want.pct)
                begin
                    $display("%0t: true_percent_q8 expected %0d got %0d",
                             $time, want.pct, m_tdata[36:22]);
                    mismatch_count++;
                end
                if (m_tdata[39:37] !== 3'b000)
                begin
                    $display("%0t: tdata padding expected 0 got %b", $time, m_tdata[39:37]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        window_configure(11'd1024);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_length();
        test_short_windows();
        test_length_clamp();
        test_random_lengths();
        test_output_backpressure();
        test_full_window();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
